// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used across the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, ignored during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Implication in the next cycle, ignored during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Implication in the next cycle, checked during reset as well.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/cpps_pkg.sv =====
// ----------------------------------------------------------------------------
// Pursuit step package
// Constants shared by the divider cell, the top level and the testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package cpps_pkg;
   localparam int POS_WIDTH_DEFAULT = 16;
   localparam int SPEED_WIDTH = 15;
   localparam int OUT_WIDTH = 17;
   localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = 15'd1024;
endpackage

`default_nettype wire

// ===== src/clamped_pursuit_position_step.sv =====
// ----------------------------------------------------------------------------
// Clamped pursuit position step
// Steps a follower toward a target by step_speed along the line between
// them, never past the target.
// ----------------------------------------------------------------------------
// The block takes one position pair in every cycle and never raises busy.
// Each result passes through two input stages, one square root cell per
// root bit, a multiply stage, fifteen divider cells and the output register
// and is shown for one cycle on rsp_strobe; the receiver cannot stall, so
// results must be taken as they come. Write step_speed only while no item is
// in flight.
`default_nettype none

module clamped_pursuit_position_step #(
   parameter int POS_WIDTH = cpps_pkg::POS_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [POS_WIDTH-1:0]   req_target_x,
   input  wire logic [POS_WIDTH-1:0]   req_target_y,
   input  wire logic [POS_WIDTH-1:0]   req_follower_x,
   input  wire logic [POS_WIDTH-1:0]   req_follower_y,
   output logic                        rsp_strobe,
   output logic [cpps_pkg::OUT_WIDTH-1:0] rsp_step_x,
   output logic [cpps_pkg::OUT_WIDTH-1:0] rsp_step_y,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [cpps_pkg::SPEED_WIDTH-1:0] csr_step_speed
);
   import cpps_pkg::*;
   `include "assert_macros.svh"

   localparam int OW = POS_WIDTH + 1;
   localparam int R = POS_WIDTH + 2;
   localparam int SQ_SIDE = 2 + 2 * OW;
   localparam int NW = OW + SPEED_WIDTH;

   logic [SPEED_WIDTH-1:0] speed_ff;

   logic              va_ff;
   logic              sgx_a_ff, sgy_a_ff;
   logic [OW-1:0]     mx_a_ff, my_a_ff;
   logic [OW-1:0]     dx, dy;

   logic              vb_ff;
   logic [2*R-1:0]    rad_b_ff;
   logic [SQ_SIDE-1:0] side_b_ff;

   logic              sq_v    [0:R];
   logic [2*R-1:0]    sq_rad  [0:R];
   logic [R+1:0]      sq_rem  [0:R];
   logic [R-1:0]      sq_root [0:R];
   logic [SQ_SIDE-1:0] sq_side [0:R];

   logic              vm_ff;
   logic [NW-1:0]     nx_ff, ny_ff;
   logic [R-1:0]      dist_m_ff;
   logic [SQ_SIDE-1:0] side_m_ff;
   logic [OW-1:0]     sq_mx, sq_my;

   logic                   dv_v    [0:SPEED_WIDTH];
   logic [R-1:0]           dv_dist [0:SPEED_WIDTH];
   logic [R-1:0]           dv_rx   [0:SPEED_WIDTH];
   logic [R-1:0]           dv_ry   [0:SPEED_WIDTH];
   logic [SPEED_WIDTH-1:0] dv_nx   [0:SPEED_WIDTH];
   logic [SPEED_WIDTH-1:0] dv_ny   [0:SPEED_WIDTH];
   logic [SPEED_WIDTH-1:0] dv_qx   [0:SPEED_WIDTH];
   logic [SPEED_WIDTH-1:0] dv_qy   [0:SPEED_WIDTH];
   logic [SQ_SIDE-1:0]     dv_side [0:SPEED_WIDTH];

   logic                 out_v_ff;
   logic [OUT_WIDTH-1:0] out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic                 fsx, fsy;
   logic [OW-1:0]        fmx, fmy;
   logic [OW:0]          selx, sely;
   logic [OW:0]          qxe, qye;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= SPEED_RESET;
      end else if (csr_valid && csr_ready) begin
         speed_ff <= csr_step_speed;
      end
   end

   always_comb begin
      dx = OW'($signed(req_target_x)) - OW'($signed(req_follower_x));
      dy = OW'($signed(req_target_y)) - OW'($signed(req_follower_y));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vm_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         va_ff <= start && !busy;
         vb_ff <= va_ff;
         vm_ff <= sq_v[R];
         out_v_ff <= dv_v[SPEED_WIDTH];
      end
      sgx_a_ff <= dx[OW-1];
      sgy_a_ff <= dy[OW-1];
      mx_a_ff <= dx[OW-1] ? (~dx + 1'b1) : dx;
      my_a_ff <= dy[OW-1] ? (~dy + 1'b1) : dy;
      rad_b_ff <= (2*R)'(mx_a_ff * mx_a_ff) + (2*R)'(my_a_ff * my_a_ff);
      side_b_ff <= {sgx_a_ff, sgy_a_ff, mx_a_ff, my_a_ff};
      nx_ff <= NW'(sq_mx) * NW'(speed_ff);
      ny_ff <= NW'(sq_my) * NW'(speed_ff);
      dist_m_ff <= sq_root[R];
      side_m_ff <= sq_side[R];
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
   end

   assign sq_v[0] = vb_ff;
   assign sq_rad[0] = rad_b_ff;
   assign sq_rem[0] = '0;
   assign sq_root[0] = '0;
   assign sq_side[0] = side_b_ff;

   for (genvar i = 0; i < R; i++) begin : g_sqrt
      cpps_sqrt_cell #(.ROOT_WIDTH(R), .SIDE_WIDTH(SQ_SIDE)) u_cell (
         .clock(clock), .reset(reset),
         .valid_in(sq_v[i]), .rad_in(sq_rad[i]), .rem_in(sq_rem[i]),
         .root_in(sq_root[i]), .side_in(sq_side[i]),
         .valid_out(sq_v[i+1]), .rad_out(sq_rad[i+1]), .rem_out(sq_rem[i+1]),
         .root_out(sq_root[i+1]), .side_out(sq_side[i+1])
      );
   end

   assign sq_mx = sq_side[R][2*OW-1:OW];
   assign sq_my = sq_side[R][OW-1:0];

   assign dv_v[0] = vm_ff;
   assign dv_dist[0] = dist_m_ff;
   assign dv_rx[0] = R'(nx_ff[NW-1:SPEED_WIDTH]);
   assign dv_ry[0] = R'(ny_ff[NW-1:SPEED_WIDTH]);
   assign dv_nx[0] = nx_ff[SPEED_WIDTH-1:0];
   assign dv_ny[0] = ny_ff[SPEED_WIDTH-1:0];
   assign dv_qx[0] = '0;
   assign dv_qy[0] = '0;
   assign dv_side[0] = side_m_ff;

   for (genvar j = 0; j < SPEED_WIDTH; j++) begin : g_div
      cpps_div_cell #(.DIV_WIDTH(R), .SIDE_WIDTH(SQ_SIDE)) u_cell (
         .clock(clock), .reset(reset),
         .valid_in(dv_v[j]), .dist_in(dv_dist[j]),
         .rem_x_in(dv_rx[j]), .rem_y_in(dv_ry[j]),
         .num_x_in(dv_nx[j]), .num_y_in(dv_ny[j]),
         .quo_x_in(dv_qx[j]), .quo_y_in(dv_qy[j]), .side_in(dv_side[j]),
         .valid_out(dv_v[j+1]), .dist_out(dv_dist[j+1]),
         .rem_x_out(dv_rx[j+1]), .rem_y_out(dv_ry[j+1]),
         .num_x_out(dv_nx[j+1]), .num_y_out(dv_ny[j+1]),
         .quo_x_out(dv_qx[j+1]), .quo_y_out(dv_qy[j+1]),
         .side_out(dv_side[j+1])
      );
   end

   always_comb begin
      fsx = dv_side[SPEED_WIDTH][SQ_SIDE-1];
      fsy = dv_side[SPEED_WIDTH][SQ_SIDE-2];
      fmx = dv_side[SPEED_WIDTH][2*OW-1:OW];
      fmy = dv_side[SPEED_WIDTH][OW-1:0];
      qxe = (OW+1)'(dv_qx[SPEED_WIDTH]);
      qye = (OW+1)'(dv_qy[SPEED_WIDTH]);
      selx = (qxe < {1'b0, fmx}) ? qxe : {1'b0, fmx};
      sely = (qye < {1'b0, fmy}) ? qye : {1'b0, fmy};
      if (dv_dist[SPEED_WIDTH] == '0) begin
         out_x_in = '0;
         out_y_in = '0;
      end else begin
         out_x_in = fsx ? OUT_WIDTH'(~selx + 1'b1) : OUT_WIDTH'(selx);
         out_y_in = fsy ? OUT_WIDTH'(~sely + 1'b1) : OUT_WIDTH'(sely);
      end
   end

   assign rsp_strobe = out_v_ff;
   assign rsp_step_x = out_x_ff;
   assign rsp_step_y = out_y_ff;

   `ASSERT_IMPL(a_strobe_from_pipe, clock, reset, rsp_strobe, $past(dv_v[SPEED_WIDTH]))
   `ASSERT_NEXT(a_csr_write, clock, reset, csr_valid && csr_ready,
                speed_ff == $past(csr_step_speed))
   `ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_strobe && !va_ff)
endmodule

`default_nettype wire

// ===== src/cpps_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// One restoring square root step: brings in two radicand bits, yields one
// root bit, and registers everything for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cpps_sqrt_cell #(
   parameter int ROOT_WIDTH = 18,
   parameter int SIDE_WIDTH = 36
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      valid_in,
   input  wire logic [2*ROOT_WIDTH-1:0]   rad_in,
   input  wire logic [ROOT_WIDTH+1:0]     rem_in,
   input  wire logic [ROOT_WIDTH-1:0]     root_in,
   input  wire logic [SIDE_WIDTH-1:0]     side_in,
   output logic                           valid_out,
   output logic [2*ROOT_WIDTH-1:0]        rad_out,
   output logic [ROOT_WIDTH+1:0]          rem_out,
   output logic [ROOT_WIDTH-1:0]          root_out,
   output logic [SIDE_WIDTH-1:0]          side_out
);
   localparam int RW = ROOT_WIDTH + 2;

   logic                    valid_ff;
   logic [2*ROOT_WIDTH-1:0] rad_ff, rad_in_next;
   logic [RW-1:0]           rem_ff, rem_in_next;
   logic [ROOT_WIDTH-1:0]   root_ff, root_in_next;
   logic [SIDE_WIDTH-1:0]   side_ff;
   logic [RW-1:0]           shifted;
   logic [RW-1:0]           trial;

   always_comb begin
      shifted = {rem_in[RW-3:0], rad_in[2*ROOT_WIDTH-1 -: 2]};
      trial = {root_in, 2'b01};
      rad_in_next = {rad_in[2*ROOT_WIDTH-3:0], 2'b00};
      if (shifted >= trial) begin
         rem_in_next = shifted - trial;
         root_in_next = {root_in[ROOT_WIDTH-2:0], 1'b1};
      end else begin
         rem_in_next = shifted;
         root_in_next = {root_in[ROOT_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rad_ff <= rad_in_next;
      rem_ff <= rem_in_next;
      root_ff <= root_in_next;
      side_ff <= side_in;
   end

   assign valid_out = valid_ff;
   assign rad_out = rad_ff;
   assign rem_out = rem_ff;
   assign root_out = root_ff;
   assign side_out = side_ff;
endmodule

`default_nettype wire

// ===== src/cpps_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step on both axes against the shared distance.
// ----------------------------------------------------------------------------
`default_nettype none

module cpps_div_cell #(
   parameter int DIV_WIDTH = 18,
   parameter int SIDE_WIDTH = 36
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 valid_in,
   input  wire logic [DIV_WIDTH-1:0] dist_in,
   input  wire logic [DIV_WIDTH-1:0] rem_x_in,
   input  wire logic [DIV_WIDTH-1:0] rem_y_in,
   input  wire logic [cpps_pkg::SPEED_WIDTH-1:0] num_x_in,
   input  wire logic [cpps_pkg::SPEED_WIDTH-1:0] num_y_in,
   input  wire logic [cpps_pkg::SPEED_WIDTH-1:0] quo_x_in,
   input  wire logic [cpps_pkg::SPEED_WIDTH-1:0] quo_y_in,
   input  wire logic [SIDE_WIDTH-1:0] side_in,
   output logic                      valid_out,
   output logic [DIV_WIDTH-1:0]      dist_out,
   output logic [DIV_WIDTH-1:0]      rem_x_out,
   output logic [DIV_WIDTH-1:0]      rem_y_out,
   output logic [cpps_pkg::SPEED_WIDTH-1:0] num_x_out,
   output logic [cpps_pkg::SPEED_WIDTH-1:0] num_y_out,
   output logic [cpps_pkg::SPEED_WIDTH-1:0] quo_x_out,
   output logic [cpps_pkg::SPEED_WIDTH-1:0] quo_y_out,
   output logic [SIDE_WIDTH-1:0]     side_out
);
   import cpps_pkg::*;

   logic                   valid_ff;
   logic [DIV_WIDTH-1:0]   dist_ff;
   logic [DIV_WIDTH-1:0]   rem_x_ff, rem_x_in_next, rem_y_ff, rem_y_in_next;
   logic [SPEED_WIDTH-1:0] num_x_ff, num_y_ff, quo_x_ff, quo_y_ff;
   logic [SPEED_WIDTH-1:0] quo_x_in_next, quo_y_in_next;
   logic [SIDE_WIDTH-1:0]  side_ff;
   logic [DIV_WIDTH:0]     sx, sy, dext;

   always_comb begin
      dext = {1'b0, dist_in};
      sx = {rem_x_in, num_x_in[SPEED_WIDTH-1]};
      sy = {rem_y_in, num_y_in[SPEED_WIDTH-1]};
      if (sx >= dext) begin
         rem_x_in_next = DIV_WIDTH'(sx - dext);
         quo_x_in_next = {quo_x_in[SPEED_WIDTH-2:0], 1'b1};
      end else begin
         rem_x_in_next = sx[DIV_WIDTH-1:0];
         quo_x_in_next = {quo_x_in[SPEED_WIDTH-2:0], 1'b0};
      end
      if (sy >= dext) begin
         rem_y_in_next = DIV_WIDTH'(sy - dext);
         quo_y_in_next = {quo_y_in[SPEED_WIDTH-2:0], 1'b1};
      end else begin
         rem_y_in_next = sy[DIV_WIDTH-1:0];
         quo_y_in_next = {quo_y_in[SPEED_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      dist_ff <= dist_in;
      rem_x_ff <= rem_x_in_next;
      rem_y_ff <= rem_y_in_next;
      num_x_ff <= {num_x_in[SPEED_WIDTH-2:0], 1'b0};
      num_y_ff <= {num_y_in[SPEED_WIDTH-2:0], 1'b0};
      quo_x_ff <= quo_x_in_next;
      quo_y_ff <= quo_y_in_next;
      side_ff <= side_in;
   end

   assign valid_out = valid_ff;
   assign dist_out = dist_ff;
   assign rem_x_out = rem_x_ff;
   assign rem_y_out = rem_y_ff;
   assign num_x_out = num_x_ff;
   assign num_y_out = num_y_ff;
   assign quo_x_out = quo_x_ff;
   assign quo_y_out = quo_y_ff;
   assign side_out = side_ff;
endmodule

`default_nettype wire

// ===== dv/clamped_pursuit_position_step_tb.sv =====
// ----------------------------------------------------------------------------
// Clamped pursuit position step testbench
// Drives position pairs through the command port at random pace, predicts
// each clamped step with a behavioral divider and square root, and checks
// every strobed result against the oldest prediction. Speed is changed
// between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clamped_pursuit_position_step_tb;
   import cpps_pkg::*;

   localparam int PW = POS_WIDTH_DEFAULT;
   localparam int LATENCY = PW + 21;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] sx;
      logic [OUT_WIDTH-1:0] sy;
   } step_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [PW-1:0] req_target_x = '0;
   logic [PW-1:0] req_target_y = '0;
   logic [PW-1:0] req_follower_x = '0;
   logic [PW-1:0] req_follower_y = '0;
   logic rsp_strobe;
   logic [OUT_WIDTH-1:0] rsp_step_x;
   logic [OUT_WIDTH-1:0] rsp_step_y;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [SPEED_WIDTH-1:0] csr_step_speed = '0;

   logic [SPEED_WIDTH-1:0] speed_now = SPEED_RESET;
   step_pair_type pending_steps[$];
   int errors = 0;

   clamped_pursuit_position_step #(.POS_WIDTH(PW)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .req_follower_x(req_follower_x), .req_follower_y(req_follower_y),
      .rsp_strobe(rsp_strobe), .rsp_step_x(rsp_step_x), .rsp_step_y(rsp_step_y),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_step_speed(csr_step_speed)
   );

   always #5 clock = ~clock;

   function automatic longint floor_sqrt(longint v);
      longint r;
      longint b;
      r = 0;
      for (int i = 20; i >= 0; i--) begin
         b = r + (longint'(1) << i);
         if (b * b <= v) r = b;
      end
      return r;
   endfunction

   function automatic logic [OUT_WIDTH-1:0] clamp_axis(longint off, longint span);
      longint mag;
      longint q;
      longint res;
      if (span == 0) return '0;
      mag = off < 0 ? -off : off;
      q = (mag * longint'(speed_now)) / span;
      res = q < mag ? q : mag;
      if (off < 0) res = -res;
      return res[OUT_WIDTH-1:0];
   endfunction

   function automatic step_pair_type pursuit_step(logic signed [PW-1:0] tx,
         logic signed [PW-1:0] ty, logic signed [PW-1:0] fx, logic signed [PW-1:0] fy);
      longint dx;
      longint dy;
      longint span;
      step_pair_type p;
      dx = longint'(tx) - longint'(fx);
      dy = longint'(ty) - longint'(fy);
      span = floor_sqrt(dx * dx + dy * dy);
      p.sx = clamp_axis(dx, span);
      p.sy = clamp_axis(dy, span);
      return p;
   endfunction

   task automatic send_positions(logic [PW-1:0] tx, logic [PW-1:0] ty,
         logic [PW-1:0] fx, logic [PW-1:0] fy, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_target_x <= tx;
      req_target_y <= ty;
      req_follower_x <= fx;
      req_follower_y <= fy;
      do @(posedge clock); while (busy);
      pending_steps.push_back(pursuit_step(tx, ty, fx, fy));
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_steps.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_speed(logic [SPEED_WIDTH-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_step_speed <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      speed_now = value;
   endtask

   always @(posedge clock) begin
      step_pair_type e;
      if (!reset && rsp_strobe) begin
         if (pending_steps.size() == 0) begin
            $error("unexpected result step_x=%0h step_y=%0h", rsp_step_x, rsp_step_y);
            errors++;
         end else begin
            e = pending_steps.pop_front();
            if (rsp_step_x !== e.sx) begin
               $error("step_x expected %0h actual %0h", e.sx, rsp_step_x);
               errors++;
            end
            if (rsp_step_y !== e.sy) begin
               $error("step_y expected %0h actual %0h", e.sy, rsp_step_y);
               errors++;
            end
         end
      end
   end

   function automatic logic [PW-1:0] rand_pos(int mode);
      case (mode)
         0: return PW'($urandom);
         1: return PW'($urandom_range(0, 15)) - PW'(8);
         2: return $urandom_range(0, 1) ? {1'b0, {(PW-1){1'b1}}} : {1'b1, {(PW-1){1'b0}}};
         default: return PW'($urandom_range(0, 4095)) - PW'(2048);
      endcase
   endfunction

   task automatic random_items(int n, bit paced);
      int mode;
      logic [PW-1:0] tx;
      logic [PW-1:0] ty;
      for (int i = 0; i < n; i++) begin
         mode = $urandom_range(0, 3);
         tx = rand_pos(mode);
         ty = rand_pos(mode);
         if ($urandom_range(0, 15) == 0)
            send_positions(tx, ty, tx, ty, paced ? $urandom_range(0, 12) : 0);
         else
            send_positions(tx, ty, rand_pos($urandom_range(0, 3)),
               rand_pos($urandom_range(0, 3)), paced ? $urandom_range(0, 12) : 0);
      end
   endtask

   task automatic test_directed;
      localparam logic [PW-1:0] MAXP = {1'b0, {(PW-1){1'b1}}};
      localparam logic [PW-1:0] MINP = {1'b1, {(PW-1){1'b0}}};
      send_positions('0, '0, '0, '0, 0);
      send_positions(16'sd500, 16'sd500, 16'sd500, 16'sd500, 0);
      send_positions(MAXP, MAXP, MINP, MINP, 1);
      send_positions(MINP, MINP, MAXP, MAXP, 0);
      send_positions(MAXP, MINP, MINP, MAXP, 2);
      send_positions(MAXP, '0, MINP, '0, 0);
      send_positions('0, MINP, '0, MAXP, 0);
      send_positions(16'sd3000, 16'sd0, 16'sd0, 16'sd0, 0);
      send_positions(16'sd0, 16'sd0, 16'sd0, 16'sd4000, 3);
      send_positions(16'sd1, 16'sd0, 16'sd0, 16'sd0, 0);
      send_positions(16'sd3072, 16'sd4096, 16'sd0, 16'sd0, 0);
      send_positions(16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 0);
      send_positions(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 0);
   endtask

   task automatic test_speed_extremes;
      write_speed('0);
      test_directed();
      random_items(60, 1'b1);
      write_speed({SPEED_WIDTH{1'b1}});
      test_directed();
      random_items(60, 1'b1);
   endtask

   task automatic test_random_speeds;
      for (int p = 0; p < 8; p++) begin
         write_speed(SPEED_WIDTH'($urandom_range(0, (1 << SPEED_WIDTH) - 1)));
         random_items(60, 1'b1);
         random_items(60, 1'b0);
         drain();
         random_items(10, 1'b1);
      end
      write_speed(SPEED_RESET);
      random_items(100, 1'b1);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      random_items(40, 1'b0);
      test_speed_extremes();
      test_random_speeds();
      drain();
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule
